/* hdl/fapr_pkg.sv */
package fapr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 15;

    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam int AMP_BITS     = 12;
    localparam int POS_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PED_BR = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PED_TL = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PED_BL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PED_TR = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT  = 3'd4;

    localparam logic [CFG_BITS-1:0] PED_BR_RST = 12'd300;
    localparam logic [CFG_BITS-1:0] PED_TL_RST = 12'd120;
    localparam logic [CFG_BITS-1:0] PED_BL_RST = 12'd160;
    localparam logic [CFG_BITS-1:0] PED_TR_RST = 12'd180;
    localparam logic [CFG_BITS-1:0] LIMIT_RST  = 12'd3840;

    typedef struct packed {
        logic [AMP_BITS-1:0]        amp_br;
        logic [AMP_BITS-1:0]        amp_tl;
        logic [AMP_BITS-1:0]        amp_bl;
        logic [AMP_BITS-1:0]        amp_tr;
        logic signed [POS_BITS-1:0] x_pos;
        logic signed [POS_BITS-1:0] y_pos;
    } t_result;

endpackage

/* hdl/four_anode_position_ratio.sv */
// Four-corner charge-division position.
// Input channel: i_in_valid / o_in_stall carry one event of four corner samples a beat.
// Output channel: o_out_valid / i_out_stall carry amplitudes and x/y positions a beat.
// Each corner lane subtracts its pedestal and checks the window; events with any
// corner rejected are dropped at the merge stage and give no output beat.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (pedestals 0..3,
// upper limit 4); write only while the block is idle.
// Pipeline: one corner stage, one merge stage, FRAC_BITS divider stages, output register.
// Throughput: one event per cycle while o_in_stall is low, set by the fully pipelined
// restoring dividers (one quotient bit per stage, one divider per axis).
// Stall: a two-entry output buffer absorbs the beat in flight; the pipeline and
// the input side stall only once that buffer is full, so o_in_stall is registered.
// Reset: clears all valids and loads the default pedestals and upper limit.
module four_anode_position_ratio #(
    parameter int SAMPLE_BITS = fapr_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fapr_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fapr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [fapr_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [SAMPLE_BITS-1:0]               i_sample_bottom_right,
    input  logic [SAMPLE_BITS-1:0]               i_sample_top_left,
    input  logic [SAMPLE_BITS-1:0]               i_sample_bottom_left,
    input  logic [SAMPLE_BITS-1:0]               i_sample_top_right,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [fapr_pkg::AMP_BITS-1:0]        o_amp_bottom_right,
    output logic [fapr_pkg::AMP_BITS-1:0]        o_amp_top_left,
    output logic [fapr_pkg::AMP_BITS-1:0]        o_amp_bottom_left,
    output logic [fapr_pkg::AMP_BITS-1:0]        o_amp_top_right,
    output logic signed [fapr_pkg::POS_BITS-1:0] o_x_position,
    output logic signed [fapr_pkg::POS_BITS-1:0] o_y_position
);
    import fapr_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SW    = SB + 2;
    localparam int XSIDE = 4 * SB + 1;

    logic [CFG_BITS-1:0] r_ped_br;
    logic [CFG_BITS-1:0] r_ped_tl;
    logic [CFG_BITS-1:0] r_ped_bl;
    logic [CFG_BITS-1:0] r_ped_tr;
    logic [CFG_BITS-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_br <= PED_BR_RST;
            r_ped_tl <= PED_TL_RST;
            r_ped_bl <= PED_BL_RST;
            r_ped_tr <= PED_TR_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PED_BR: r_ped_br <= i_cfg_data;
                CFG_PED_TL: r_ped_tl <= i_cfg_data;
                CFG_PED_BL: r_ped_bl <= i_cfg_data;
                CFG_PED_TR: r_ped_tr <= i_cfg_data;
                CFG_LIMIT:  r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;
    logic r_s_valid;

    assign en     = !r_s_valid;
    assign accept = i_in_valid && en;

    // corner lanes
    logic [SB-1:0] amp_br, amp_tl, amp_bl, amp_tr;
    logic ok_br, ok_tl, ok_bl, ok_tr;

    fapr_corner #(.SAMPLE_BITS(SB)) u_br (
        .i_clk(i_clk), .i_en(en), .i_sample(i_sample_bottom_right),
        .i_pedestal(r_ped_br), .i_limit(r_limit), .o_amp(amp_br), .o_ok(ok_br)
    );
    fapr_corner #(.SAMPLE_BITS(SB)) u_tl (
        .i_clk(i_clk), .i_en(en), .i_sample(i_sample_top_left),
        .i_pedestal(r_ped_tl), .i_limit(r_limit), .o_amp(amp_tl), .o_ok(ok_tl)
    );
    fapr_corner #(.SAMPLE_BITS(SB)) u_bl (
        .i_clk(i_clk), .i_en(en), .i_sample(i_sample_bottom_left),
        .i_pedestal(r_ped_bl), .i_limit(r_limit), .o_amp(amp_bl), .o_ok(ok_bl)
    );
    fapr_corner #(.SAMPLE_BITS(SB)) u_tr (
        .i_clk(i_clk), .i_en(en), .i_sample(i_sample_top_right),
        .i_pedestal(r_ped_tr), .i_limit(r_limit), .o_amp(amp_tr), .o_ok(ok_tr)
    );

    // merge stage
    logic [SB:0]   x_pos_sum, x_neg_sum, y_pos_sum, y_neg_sum;
    logic [SW-1:0] n_sum;
    logic          n_xneg, n_yneg;
    logic [SB:0]   n_xmag, n_ymag;

    assign x_pos_sum = (SB+1)'(amp_br) + (SB+1)'(amp_tr);
    assign x_neg_sum = (SB+1)'(amp_tl) + (SB+1)'(amp_bl);
    assign y_pos_sum = (SB+1)'(amp_tl) + (SB+1)'(amp_tr);
    assign y_neg_sum = (SB+1)'(amp_br) + (SB+1)'(amp_bl);
    assign n_sum     = SW'(x_pos_sum) + SW'(x_neg_sum);
    assign n_xneg    = x_neg_sum > x_pos_sum;
    assign n_yneg    = y_neg_sum > y_pos_sum;
    assign n_xmag    = n_xneg ? x_neg_sum - x_pos_sum : x_pos_sum - x_neg_sum;
    assign n_ymag    = n_yneg ? y_neg_sum - y_pos_sum : y_pos_sum - y_neg_sum;

    logic          r_v0, r_v1;
    logic [SW-1:0] r_sum, r_xmag, r_ymag;
    logic [XSIDE-1:0] r_xside;
    logic          r_yneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum   <= n_sum;
            r_xmag  <= SW'(n_xmag);
            r_ymag  <= SW'(n_ymag);
            r_xside <= {amp_br, amp_tl, amp_bl, amp_tr, n_xneg};
            r_yneg  <= n_yneg;
        end
    end

    // dividers, one lane per axis
    logic [FRAC_BITS-1:0] x_quot, y_quot;
    logic [XSIDE-1:0]     x_side;
    logic                 y_side;
    logic [FRAC_BITS-1:0] r_vdiv;

    fapr_div #(.NUM_BITS(SW), .STEPS(FRAC_BITS), .SIDE_BITS(XSIDE)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_xmag), .i_den(r_sum),
        .i_side(r_xside), .o_quot(x_quot), .o_side(x_side)
    );
    fapr_div #(.NUM_BITS(SW), .STEPS(FRAC_BITS), .SIDE_BITS(1)) u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_ymag), .i_den(r_sum),
        .i_side(r_yneg), .o_quot(y_quot), .o_side(y_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_vdiv <= '0;
        end else if (en) begin
            r_v0   <= accept;
            r_v1   <= r_v0 && ok_br && ok_tl && ok_bl && ok_tr;
            r_vdiv <= {r_vdiv[FRAC_BITS-2:0], r_v1};
        end
    end

    // result formation and output buffer
    t_result n_res;
    logic [POS_BITS-1:0] x_mag16, y_mag16;

    assign x_mag16      = POS_BITS'(x_quot);
    assign y_mag16      = POS_BITS'(y_quot);
    assign n_res.amp_br = AMP_BITS'(x_side[4*SB:3*SB+1]);
    assign n_res.amp_tl = AMP_BITS'(x_side[3*SB:2*SB+1]);
    assign n_res.amp_bl = AMP_BITS'(x_side[2*SB:SB+1]);
    assign n_res.amp_tr = AMP_BITS'(x_side[SB:1]);
    assign n_res.x_pos  = x_side[0] ? -x_mag16 : x_mag16;
    assign n_res.y_pos  = y_side ? -y_mag16 : y_mag16;

    t_result r_o, r_s;
    logic    r_o_valid;
    logic    take;
    logic    pipe_out;

    assign take     = r_o_valid && !i_out_stall;
    assign pipe_out = r_vdiv[FRAC_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (take) begin
                r_o       <= r_s;
                r_s_valid <= 1'b0;
            end
        end else if (!r_o_valid || take) begin
            r_o       <= n_res;
            r_o_valid <= pipe_out;
        end else if (pipe_out) begin
            r_s       <= n_res;
            r_s_valid <= 1'b1;
        end
    end

    assign o_in_stall         = r_s_valid;
    assign o_out_valid        = r_o_valid;
    assign o_amp_bottom_right = r_o.amp_br;
    assign o_amp_top_left     = r_o.amp_tl;
    assign o_amp_bottom_left  = r_o.amp_bl;
    assign o_amp_top_right    = r_o.amp_tr;
    assign o_x_position       = r_o.x_pos;
    assign o_y_position       = r_o.y_pos;

endmodule

/* hdl/fapr_corner.sv */
module fapr_corner #(
    parameter int SAMPLE_BITS = fapr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [fapr_pkg::CFG_BITS-1:0] i_pedestal,
    input  logic [fapr_pkg::CFG_BITS-1:0] i_limit,
    output logic [SAMPLE_BITS-1:0]        o_amp,
    output logic                          o_ok
);
    import fapr_pkg::*;

    localparam int CW = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

    logic [CW-1:0] s_wide;
    logic [CW-1:0] p_wide;
    logic [CW-1:0] l_wide;
    logic [CW-1:0] d_wide;
    logic [SAMPLE_BITS-1:0] r_amp;
    logic r_ok;

    assign s_wide = CW'(i_sample);
    assign p_wide = CW'(i_pedestal);
    assign l_wide = CW'(i_limit);
    assign d_wide = s_wide - p_wide;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amp <= SAMPLE_BITS'(d_wide);
            r_ok  <= (s_wide > p_wide) && (s_wide < l_wide);
        end
    end

    assign o_amp = r_amp;
    assign o_ok  = r_ok;

endmodule

/* hdl/fapr_div.sv */
module fapr_div #(
    parameter int NUM_BITS  = 14,
    parameter int STEPS     = fapr_pkg::FRAC_BITS_DEF,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [NUM_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic [STEPS-1:0]     o_quot,
    output logic [SIDE_BITS-1:0] o_side
);

    // restoring division, one quotient bit per stage; i_num < i_den
    logic [NUM_BITS-1:0]  r_rem  [STEPS-1];
    logic [NUM_BITS-1:0]  r_den  [STEPS-1];
    logic [STEPS-1:0]     r_quo  [STEPS];
    logic [SIDE_BITS-1:0] r_side [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [NUM_BITS-1:0]  rem_in;
        logic [NUM_BITS-1:0]  den_in;
        logic [STEPS-1:0]     quo_in;
        logic [SIDE_BITS-1:0] side_in;
        logic [NUM_BITS:0]    dbl;
        logic [NUM_BITS:0]    diff;
        logic                 take;

        if (k == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        assign dbl  = {rem_in, 1'b0};
        assign diff = dbl - {1'b0, den_in};
        assign take = !diff[NUM_BITS];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k]  <= {quo_in[STEPS-2:0], take};
                r_side[k] <= side_in;
            end
        end

        if (k < STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? diff[NUM_BITS-1:0] : dbl[NUM_BITS-1:0];
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quot = r_quo[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule

/* hdl/fapr_checker.sv */
module fapr_props (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [fapr_pkg::AMP_BITS-1:0] o_amp_bottom_right,
    input logic [fapr_pkg::AMP_BITS-1:0] o_amp_top_left,
    input logic [fapr_pkg::AMP_BITS-1:0] o_amp_bottom_left,
    input logic [fapr_pkg::AMP_BITS-1:0] o_amp_top_right
);
    import fapr_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("valid or stall set after reset");

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_stall_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && !(o_out_valid && i_out_stall)) |=> !o_in_stall)
        else $error("input stall raised without output back-pressure");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped under stall");

    a_amps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_amp_bottom_right != '0 && o_amp_top_left != '0 &&
                         o_amp_bottom_left != '0 && o_amp_top_right != '0))
        else $error("result with a zero amplitude");

endmodule

bind four_anode_position_ratio fapr_props u_fapr_props (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_amp_bottom_right (o_amp_bottom_right),
    .o_amp_top_left     (o_amp_top_left),
    .o_amp_bottom_left  (o_amp_bottom_left),
    .o_amp_top_right    (o_amp_top_right)
);

/* tb/fapr_checker.sv */
`timescale 1ns / 1ps

module fapr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fapr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [fapr_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [fapr_pkg::SAMPLE_BITS_DEF-1:0] i_sample_br,
    input  logic [fapr_pkg::SAMPLE_BITS_DEF-1:0] i_sample_tl,
    input  logic [fapr_pkg::SAMPLE_BITS_DEF-1:0] i_sample_bl,
    input  logic [fapr_pkg::SAMPLE_BITS_DEF-1:0] i_sample_tr,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  fapr_pkg::t_result                   i_result,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import fapr_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int MAX_REPORTS = 10;

    logic [CFG_BITS-1:0] ped_br, ped_tl, ped_bl, ped_tr, limit;
    t_result             awaited_positions[$];
    t_result             exp_beat, new_beat;
    int                  fails = 0;

    function automatic logic [AMP_BITS-1:0] corner_amp(input logic [SB-1:0] s,
                                                       input logic [CFG_BITS-1:0] ped);
        if (s > ped && s < limit) return AMP_BITS'(s - ped);
        return '0;
    endfunction

    // signed (pos - neg) / sum in Q1.15, truncated toward zero
    function automatic logic signed [POS_BITS-1:0] axis_ratio(input logic [13:0] pos,
                                                              input logic [13:0] neg,
                                                              input logic [13:0] sum);
        logic [31:0] mag;
        if (pos >= neg) begin
            mag = ({18'd0, 14'(pos - neg)} << FB) / {18'd0, sum};
            return mag[POS_BITS-1:0];
        end
        mag = ({18'd0, 14'(neg - pos)} << FB) / {18'd0, sum};
        return -mag[POS_BITS-1:0];
    endfunction

    function automatic bit divide_charge(input logic [SB-1:0] s_br, input logic [SB-1:0] s_tl,
                                         input logic [SB-1:0] s_bl, input logic [SB-1:0] s_tr,
                                         output t_result r);
        logic [AMP_BITS-1:0] a_br, a_tl, a_bl, a_tr;
        logic [13:0]         sum;
        a_br = corner_amp(s_br, ped_br);
        a_tl = corner_amp(s_tl, ped_tl);
        a_bl = corner_amp(s_bl, ped_bl);
        a_tr = corner_amp(s_tr, ped_tr);
        r = '0;
        if (a_br == 0 || a_tl == 0 || a_bl == 0 || a_tr == 0) return 1'b0;
        sum = 14'(a_br) + 14'(a_tl) + 14'(a_bl) + 14'(a_tr);
        r.amp_br = a_br;
        r.amp_tl = a_tl;
        r.amp_bl = a_bl;
        r.amp_tr = a_tr;
        r.x_pos  = axis_ratio(14'(a_br) + 14'(a_tr), 14'(a_tl) + 14'(a_bl), sum);
        r.y_pos  = axis_ratio(14'(a_tl) + 14'(a_tr), 14'(a_br) + 14'(a_bl), sum);
        return 1'b1;
    endfunction

    function automatic string beat_text(input t_result r);
        return $sformatf("br=%0d tl=%0d bl=%0d tr=%0d x=%0d y=%0d",
                         r.amp_br, r.amp_tl, r.amp_bl, r.amp_tr, r.x_pos, r.y_pos);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ped_br = PED_BR_RST;
            ped_tl = PED_TL_RST;
            ped_bl = PED_BL_RST;
            ped_tr = PED_TR_RST;
            limit  = LIMIT_RST;
            awaited_positions.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_positions.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("unexpected output beat: %s", beat_text(i_result));
                end else begin
                    exp_beat = awaited_positions.pop_front();
                    if (i_result.amp_br !== exp_beat.amp_br ||
                        i_result.amp_tl !== exp_beat.amp_tl ||
                        i_result.amp_bl !== exp_beat.amp_bl ||
                        i_result.amp_tr !== exp_beat.amp_tr ||
                        i_result.x_pos  !== exp_beat.x_pos  ||
                        i_result.y_pos  !== exp_beat.y_pos) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("output beat mismatch: expected %s, got %s",
                                     beat_text(exp_beat), beat_text(i_result));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (divide_charge(i_sample_br, i_sample_tl, i_sample_bl, i_sample_tr, new_beat))
                    awaited_positions.push_back(new_beat);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PED_BR: ped_br = i_cfg_data;
                    CFG_PED_TL: ped_tl = i_cfg_data;
                    CFG_PED_BL: ped_bl = i_cfg_data;
                    CFG_PED_TR: ped_tr = i_cfg_data;
                    CFG_LIMIT:  limit  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_positions.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import fapr_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = FRAC_BITS_DEF + 3 + 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 8;
    localparam int NOISY_PCT     = 20;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [SB-1:0]           i_sample_bottom_right, i_sample_top_left;
    logic [SB-1:0]           i_sample_bottom_left, i_sample_top_right;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [AMP_BITS-1:0]     o_amp_bottom_right, o_amp_top_left;
    logic [AMP_BITS-1:0]     o_amp_bottom_left, o_amp_top_right;
    logic signed [POS_BITS-1:0] o_x_position, o_y_position;

    t_result dut_result;
    int      fail_count, pending;
    int      cycle_cnt;
    int      hold_req = 0, hold_done = 0;
    bit      quiet_run = 1'b0;
    int      cur_br, cur_tl, cur_bl, cur_tr, cur_lim;

    assign dut_result = {o_amp_bottom_right, o_amp_top_left, o_amp_bottom_left,
                         o_amp_top_right, o_x_position, o_y_position};

    four_anode_position_ratio dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_sample_bottom_right (i_sample_bottom_right),
        .i_sample_top_left     (i_sample_top_left),
        .i_sample_bottom_left  (i_sample_bottom_left),
        .i_sample_top_right    (i_sample_top_right),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_amp_bottom_right    (o_amp_bottom_right),
        .o_amp_top_left        (o_amp_top_left),
        .o_amp_bottom_left     (o_amp_bottom_left),
        .o_amp_top_right       (o_amp_top_right),
        .o_x_position          (o_x_position),
        .o_y_position          (o_y_position)
    );

    fapr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample_br  (i_sample_bottom_right),
        .i_sample_tl  (i_sample_top_left),
        .i_sample_bl  (i_sample_bottom_left),
        .i_sample_tr  (i_sample_top_right),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_result     (dut_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("four_anode_position_ratio verification failed");
        $finish;
    end

    // receiver: random stall, long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end
            i_out_stall <= (!quiet_run && ($urandom_range(0, 99) < IDLE_PCT));
        end
    end

    task automatic send_event(input logic [SB-1:0] br, input logic [SB-1:0] tl,
                              input logic [SB-1:0] bl, input logic [SB-1:0] tr);
        i_in_valid            <= 1'b1;
        i_sample_bottom_right <= br;
        i_sample_top_left     <= tl;
        i_sample_bottom_left  <= bl;
        i_sample_top_right    <= tr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_BITS'(data);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int br, input int tl, input int bl, input int tr,
                                 input int lim, input bit with_spares);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(CFG_PED_BR, br);
        cfg_write(CFG_PED_TL, tl);
        cfg_write(CFG_PED_BL, bl);
        cfg_write(CFG_PED_TR, tr);
        cfg_write(CFG_LIMIT, lim);
        // indexes past the list must leave every register alone
        if (with_spares) begin
            for (int k = 1; int'(CFG_LIMIT) + k < (1 << CFG_IDX_BITS); k++)
                cfg_write(CFG_IDX_BITS'(int'(CFG_LIMIT) + k), $urandom_range(0, 4095));
        end
        i_cfg_we <= 1'b0;
        cur_br  = br;
        cur_tl  = tl;
        cur_bl  = bl;
        cur_tr  = tr;
        cur_lim = lim;
    endtask

    function automatic logic [SB-1:0] pick_sample(input int ped, input int lim, input bit noisy);
        int r;
        r = $urandom_range(0, 99);
        if (ped + 1 >= lim || (noisy && r < 50)) begin
            if (r % 5 == 0) return SB'(ped);
            if (r % 5 == 1) return SB'(lim);
            return SB'($urandom_range(0, 4095));
        end
        if (r >= 94) return SB'(ped + 1);
        if (r >= 88) return SB'(lim - 1);
        return SB'($urandom_range(lim - 1, ped + 1));
    endfunction

    task automatic run_events(input int count);
        bit noisy;
        logic [SB-1:0] s_br, s_tl, s_bl, s_tr;
        for (int n = 0; n < count; n++) begin
            maybe_pause();
            noisy = ($urandom_range(0, 99) < NOISY_PCT);
            s_br  = pick_sample(cur_br, cur_lim, noisy);
            s_tl  = pick_sample(cur_tl, cur_lim, noisy);
            s_bl  = pick_sample(cur_bl, cur_lim, noisy);
            s_tr  = pick_sample(cur_tr, cur_lim, noisy);
            send_event(s_br, s_tl, s_bl, s_tr);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        i_in_valid            = 1'b0;
        i_sample_bottom_right = '0;
        i_sample_top_left     = '0;
        i_sample_bottom_left  = '0;
        i_sample_top_right    = '0;
        cur_br  = int'(PED_BR_RST);
        cur_tl  = int'(PED_TL_RST);
        cur_bl  = int'(PED_BL_RST);
        cur_tr  = int'(PED_TR_RST);
        cur_lim = int'(LIMIT_RST);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pedestals: window edges, one dominant corner, single rejects
        send_event(301, 121, 161, 181);
        send_event(3839, 3839, 3839, 3839);
        send_event(3839, 121, 161, 181);
        send_event(301, 3839, 161, 181);
        send_event(301, 121, 3839, 181);
        send_event(301, 121, 161, 3839);
        send_event(300, 500, 500, 500);
        send_event(500, 3840, 500, 500);
        send_event(500, 500, 0, 500);
        send_event(500, 500, 500, 4095);
        send_event(0, 0, 0, 0);
        send_event(4095, 4095, 4095, 4095);
        send_event(1200, 900, 2500, 333);
        run_events(100);
        hold_req++;
        run_events(100);

        // widest window, no idling on either side
        apply_setting(0, 0, 0, 0, 4095, 1'b0);
        quiet_run = 1'b1;
        send_event(1, 1, 1, 1);
        send_event(4094, 4094, 4094, 4094);
        send_event(4094, 1, 1, 1);
        send_event(1, 1, 4094, 1);
        send_event(1, 4094, 1, 4094);
        send_event(4095, 2000, 2000, 2000);
        send_event(0, 2000, 2000, 2000);
        run_events(150);
        quiet_run = 1'b0;

        // pedestals above the limit: nothing can pass
        apply_setting(4095, 4095, 4095, 4095, 0, 1'b0);
        run_events(30);

        apply_setting(2000, 10, 3000, 500, 3500, 1'b1);
        run_events(75);
        drain_results();
        run_events(75);

        // top left pedestal equal to the limit
        apply_setting(100, 4000, 50, 60, 4000, 1'b0);
        run_events(30);

        for (int p = 0; p < 3; p++) begin
            apply_setting($urandom_range(0, 1500), $urandom_range(0, 1500),
                          $urandom_range(0, 1500), $urandom_range(0, 1500),
                          $urandom_range(2500, 4095), p == 0);
            run_events(130);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("four_anode_position_ratio verification clean");
        end else begin
            $display("four_anode_position_ratio verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/fapr_pkg.sv
hdl/fapr_corner.sv
hdl/fapr_div.sv
hdl/four_anode_position_ratio.sv
hdl/fapr_checker.sv
tb/fapr_checker.sv
tb/tb_top.sv
